// ===== design/assert_macros.svh =====
// Assertion helpers shared by the files that check their own logic.
// Each macro expects clk and rst in scope; checks are off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check a consequence in the same cycle as its trigger.
`define ASSERT_SAME(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) else $error(msg);

// Check a consequence in the cycle after its trigger.
`define ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

// ===== design/utd_pkg.sv =====
package utd_pkg;

  // Reciprocals for the time split: ceil(2^35 / 675), ceil(2^21 / 225), ceil(2^14 / 15)
  localparam logic [25:0] DayRecip  = 26'd50903317;
  localparam logic [13:0] HourRecip = 14'd9321;
  localparam logic [10:0] MinRecip  = 11'd1093;

  // Seconds per unit, used to take the remainder back off
  localparam logic [31:0] DaySecs  = 32'd86400;
  localparam logic [31:0] HourSecs = 32'd3600;
  localparam logic [11:0] MinSecs  = 12'd60;

  // Calendar constants
  localparam logic [11:0] EpochYear    = 12'd1970;
  localparam logic [1:0]  EpochMod4    = 2'd2;
  localparam logic [6:0]  EpochMod100  = 7'd70;
  localparam logic [8:0]  EpochMod400  = 9'd370;
  localparam logic [6:0]  LastMod100   = 7'd99;
  localparam logic [8:0]  LastMod400   = 9'd399;
  localparam logic [8:0]  DaysYear     = 9'd365;
  localparam logic [8:0]  DaysLeapYear = 9'd366;
  localparam logic [3:0]  MonthJan     = 4'd1;
  localparam logic [3:0]  MonthFeb     = 4'd2;
  localparam logic [3:0]  MonthDec     = 4'd12;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic day_div;
    logic day_rem;
    logic hour_div;
    logic hour_rem;
    logic min_div;
    logic walk_init;
    logic year_step;
    logic month_step;
    logic out_load;
  } utd_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic year_fit;
    logic month_fit;
  } utd_stat_t;

  // Days in a month of a common year
  function automatic logic [4:0] month_days(input logic [3:0] m);
    logic [4:0] d;
    case (m)
      4'd1:    d = 5'd31;
      4'd2:    d = 5'd28;
      4'd3:    d = 5'd31;
      4'd4:    d = 5'd30;
      4'd5:    d = 5'd31;
      4'd6:    d = 5'd30;
      4'd7:    d = 5'd31;
      4'd8:    d = 5'd31;
      4'd9:    d = 5'd30;
      4'd10:   d = 5'd31;
      4'd11:   d = 5'd30;
      4'd12:   d = 5'd31;
      default: d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

// ===== design/unix_time_to_datetime_unit.sv =====
// Channel     Signals                               Direction  Transfer
// request     start, busy, unix_time                in         start && !busy
// result      done, year, month, day, hour,         out        done (one cycle)
//             minute, second, clamped
// config      cfg_valid, cfg_ready, utc_offset      in         cfg_valid && cfg_ready
//
// A request splits the seconds by reciprocal multiplication in the states DAY_DIV,
// DAY_REM, HOUR_DIV, HOUR_REM and MIN_DIV, then passes WALK_INIT, the year walk,
// one year per cycle, and the month walk before the result is presented.
// One request is in flight; busy is high until the strobe.
// Synchronous reset clears control and the offset register (offset 0).
// Results cannot be stalled: each is valid for the single done cycle.
module unix_time_to_datetime_unit
  import utd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] unix_time,
  output logic        done,
  output logic [11:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second,
  output logic        clamped,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  utc_offset
);

  utd_cmd_t  cmd;
  utd_stat_t stat;
  logic      date_ok;
  logic      time_ok;

  // Take offset writes between requests
  assign cfg_ready = !busy;

  utd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  utd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .unix_time (unix_time),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_tz    (utc_offset),
    .stat      (stat),
    .year      (year),
    .month     (month),
    .day       (day),
    .hour      (hour),
    .minute    (minute),
    .second    (second),
    .clamped   (clamped)
  );

  // Range checks on the presented result
  assign date_ok = (month >= MonthJan) && (month <= MonthDec) && (day != 5'd0);
  assign time_ok = (hour < 5'd24) && (minute < 6'd60) && (second < 6'd60);

`include "assert_macros.svh"

  `ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
  `ASSERT_SAME(a_done_idle, done, !busy, "result strobe while still busy")
  `ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
  `ASSERT_SAME(a_done_month, done, date_ok, "month or day out of range")
  `ASSERT_SAME(a_done_time, done, time_ok, "time of day out of range")

endmodule

// ===== design/utd_ctrl.sv =====
module utd_ctrl
  import utd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  utd_stat_t stat,
  output utd_cmd_t  cmd,
  output logic      busy,
  output logic      done
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DAY_DIV,
    ST_DAY_REM,
    ST_HOUR_DIV,
    ST_HOUR_REM,
    ST_MIN_DIV,
    ST_WALK_INIT,
    ST_YEAR,
    ST_MONTH
  } state_t;

  state_t state;

  // Decode commands from the current state
  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE:      cmd.load      = start;
      ST_DAY_DIV:   cmd.day_div   = 1'b1;
      ST_DAY_REM:   cmd.day_rem   = 1'b1;
      ST_HOUR_DIV:  cmd.hour_div  = 1'b1;
      ST_HOUR_REM:  cmd.hour_rem  = 1'b1;
      ST_MIN_DIV:   cmd.min_div   = 1'b1;
      ST_WALK_INIT: cmd.walk_init = 1'b1;
      ST_YEAR:      cmd.year_step = !stat.year_fit;
      ST_MONTH: begin
        cmd.month_step = !stat.month_fit;
        cmd.out_load   = stat.month_fit;
      end
      default:      cmd = '0;
    endcase
  end

  // Sequence the request through the time split and the calendar walk
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= cmd.out_load;
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_DAY_DIV;
            busy  <= 1'b1;
          end
        end
        ST_DAY_DIV:   state <= ST_DAY_REM;
        ST_DAY_REM:   state <= ST_HOUR_DIV;
        ST_HOUR_DIV:  state <= ST_HOUR_REM;
        ST_HOUR_REM:  state <= ST_MIN_DIV;
        ST_MIN_DIV:   state <= ST_WALK_INIT;
        ST_WALK_INIT: state <= ST_YEAR;
        ST_YEAR: begin
          if (stat.year_fit) state <= ST_MONTH;
        end
        ST_MONTH: begin
          if (stat.month_fit) begin
            state <= ST_IDLE;
            busy  <= 1'b0;
          end
        end
        default: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== design/utd_dp.sv =====
module utd_dp
  import utd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  utd_cmd_t    cmd,
  input  logic [31:0] unix_time,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_tz,
  output utd_stat_t   stat,
  output logic [11:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second,
  output logic        clamped
);

  logic [4:0]         tz;
  logic [31:0]        rem;
  logic [15:0]        days;
  logic [4:0]         hour_r;
  logic [5:0]         min_r;
  logic [11:0]        year_r;
  logic [1:0]         m4;
  logic [6:0]         m100;
  logic [8:0]         m400;
  logic [3:0]         month_r;
  logic               clamp_r;

  logic signed [33:0] tz_secs;
  logic signed [33:0] local_secs;
  logic [31:0]        secs;
  logic               clamp_now;
  logic               leap;
  logic [8:0]         ylen;
  logic [4:0]         mlen;
  logic [50:0]        day_prod;
  logic [31:0]        day_secs;
  logic [25:0]        hour_prod;
  logic [31:0]        hour_secs;
  logic [19:0]        min_prod;
  logic [11:0]        min_secs;
  logic [11:0]        sec_left;

  // Form local seconds and clamp them into the 32-bit range
  always_comb begin
    tz_secs    = $signed({{29{tz[4]}}, tz}) * 34'sd3600;
    local_secs = $signed({2'b00, unix_time}) + tz_secs;
    clamp_now  = local_secs[33] || local_secs[32];
    if (local_secs[33]) secs = '0;
    else if (local_secs[32]) secs = '1;
    else secs = local_secs[31:0];
  end

  // Split the seconds by reciprocal multiplication after dropping factors of two
  always_comb begin
    day_prod  = 51'(rem[31:7]) * 51'(DayRecip);
    day_secs  = 32'(days) * DaySecs;
    hour_prod = 26'(rem[16:4]) * 26'(HourRecip);
    hour_secs = 32'(hour_r) * HourSecs;
    min_prod  = 20'(rem[11:2]) * 20'(MinRecip);
    min_secs  = 12'(min_r) * MinSecs;
    sec_left  = rem[11:0] - min_secs;
  end

  // Leap rule from the running remainders of the year
  always_comb begin
    leap = ((m4 == 2'd0) && (m100 != 7'd0)) || (m400 == 9'd0);
    ylen = leap ? DaysLeapYear : DaysYear;
    mlen = month_days(month_r) + {4'd0, (month_r == MonthFeb) && leap};
    stat.year_fit  = days < {7'd0, ylen};
    stat.month_fit = (month_r == MonthDec) || (days < {11'd0, mlen});
  end

  // Hold the time-zone offset
  always_ff @(posedge clk) begin
    if (rst) begin
      tz <= '0;
    end else if (cfg_we) begin
      tz <= cfg_tz;
    end
  end

  // Time split and calendar walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem     <= secs;
      clamp_r <= clamp_now;
    end
    if (cmd.day_div) begin
      days <= day_prod[50:35];
    end
    if (cmd.day_rem) begin
      rem <= rem - day_secs;
    end
    if (cmd.hour_div) begin
      hour_r <= hour_prod[25:21];
    end
    if (cmd.hour_rem) begin
      rem <= rem - hour_secs;
    end
    if (cmd.min_div) begin
      min_r <= min_prod[19:14];
    end
    if (cmd.walk_init) begin
      second  <= sec_left[5:0];
      year_r  <= EpochYear;
      m4      <= EpochMod4;
      m100    <= EpochMod100;
      m400    <= EpochMod400;
      month_r <= MonthJan;
    end
    // Advance one year
    if (cmd.year_step) begin
      days   <= days - {7'd0, ylen};
      year_r <= year_r + 12'd1;
      m4     <= m4 + 2'd1;
      m100   <= (m100 == LastMod100) ? 7'd0 : m100 + 7'd1;
      m400   <= (m400 == LastMod400) ? 9'd0 : m400 + 9'd1;
    end
    // Advance one month
    if (cmd.month_step) begin
      days    <= days - {11'd0, mlen};
      month_r <= month_r + 4'd1;
    end
    // Present the result
    if (cmd.out_load) begin
      year    <= year_r;
      month   <= month_r;
      day     <= days[4:0] + 5'd1;
      hour    <= hour_r;
      minute  <= min_r;
      clamped <= clamp_r;
    end
  end

endmodule

// ===== test/tb_top.sv =====
module tb_top;
  import utd_pkg::*;

  localparam int unsigned CycleLimit  = 3_000_000;
  localparam int unsigned DrainCycles = 200;
  localparam int unsigned SecsPerDay  = 86400;
  localparam int unsigned SecsPerHour = 3600;

  // Timestamp landmarks around the century leap-year rules
  localparam logic [31:0] Y2000Jan01 = 32'd946684800;
  localparam logic [31:0] Y2000Feb29 = 32'd951782400;
  localparam logic [31:0] Y2100Jan01 = 32'd4102444800;
  localparam logic [31:0] Y2100Mar01 = 32'd4107542400;
  localparam logic [31:0] TimeMax    = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        clamped;
  } calendar_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [31:0] unix_time;
  logic        done;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic        clamped;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [4:0]  utc_offset;

  calendar_t       pending_dates[$];
  logic [4:0]      tz_setting;
  int unsigned     mismatches;
  int unsigned     cycle_count;
  int unsigned     idle_pct;

  unix_time_to_datetime_unit uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .unix_time  (unix_time),
    .done       (done),
    .year       (year),
    .month      (month),
    .day        (day),
    .hour       (hour),
    .minute     (minute),
    .second     (second),
    .clamped    (clamped),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .utc_offset (utc_offset)
  );

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Gregorian leap rule: every fourth year, except centuries, except every 400th
  function automatic bit gregorian_leap(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_length(input int unsigned m, input bit leap);
    case (m)
      2:            return leap ? 29 : 28;
      4, 6, 9, 11:  return 30;
      default:      return 31;
    endcase
  endfunction

  // Convert a timestamp to local calendar fields under the given offset
  function automatic calendar_t predict_datetime(input logic [31:0] ts,
                                                 input logic [4:0] tz_raw);
    longint          local_secs;
    longint unsigned secs;
    int unsigned     days;
    int unsigned     sod;
    int unsigned     yr;
    int unsigned     mon;
    int unsigned     ylen;
    calendar_t       r;
    r.clamped  = 1'b0;
    local_secs = longint'({32'd0, ts}) + longint'($signed(tz_raw)) * longint'(SecsPerHour);
    if (local_secs < 0) begin
      secs      = 0;
      r.clamped = 1'b1;
    end else if (local_secs > 64'sh0000_0000_FFFF_FFFF) begin
      secs      = 64'h0000_0000_FFFF_FFFF;
      r.clamped = 1'b1;
    end else begin
      secs = local_secs;
    end
    days = 32'(secs / SecsPerDay);
    sod  = 32'(secs % SecsPerDay);
    // Walk whole years, then whole months
    yr   = 1970;
    ylen = 365;
    while (days >= ylen) begin
      days -= ylen;
      yr++;
      ylen = gregorian_leap(yr) ? 366 : 365;
    end
    mon = 1;
    while (mon < 12 && days >= month_length(mon, gregorian_leap(yr))) begin
      days -= month_length(mon, gregorian_leap(yr));
      mon++;
    end
    r.year   = yr[11:0];
    r.month  = mon[3:0];
    r.day    = 5'(days + 1);
    r.hour   = 5'(sod / SecsPerHour);
    r.minute = 6'((sod / 60) % 60);
    r.second = 6'(sod % 60);
    return r;
  endfunction

  // Send one request; the prediction is queued at the accepting edge
  task automatic send_request(input logic [31:0] ts);
    @(negedge clk);
    start     = 1'b1;
    unix_time = ts;
    do @(posedge clk); while (busy);
    pending_dates.push_back(predict_datetime(ts, tz_setting));
  endtask

  // Hold start low for a while, now and then a long stretch
  task automatic sender_gap();
    if ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
      if ($urandom_range(0, 7) == 0)
        repeat ($urandom_range(20, 200)) @(negedge clk);
      else
        repeat ($urandom_range(0, 7)) @(negedge clk);
    end
  endtask

  // Stop sending and wait until every predicted result has arrived
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
  endtask

  // Write the offset register; only called once the unit is idle
  task automatic write_offset(input logic [4:0] tz);
    drain();
    @(negedge clk);
    cfg_valid  = 1'b1;
    utc_offset = tz;
    do @(posedge clk); while (!cfg_ready);
    tz_setting = tz;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Pick a timestamp: uniform, or close to an edge of the calendar
  function automatic logic [31:0] pick_time();
    logic [31:0] base;
    case ($urandom_range(0, 7))
      0:       base = $urandom_range(0, 200000);
      1:       base = TimeMax - $urandom_range(0, 200000);
      2:       base = Y2000Jan01 + $urandom_range(0, 100) * SecsPerDay;
      3:       base = Y2000Feb29 - 32'd86400 + $urandom_range(0, 2 * SecsPerDay);
      4:       base = Y2100Jan01 + $urandom_range(0, 100) * SecsPerDay;
      5:       base = $urandom_range(0, 49710) * SecsPerDay + $urandom_range(0, 3) - 2;
      default: base = $urandom();
    endcase
    return base;
  endfunction

  function automatic logic [4:0] pick_offset();
    int tz;
    if ($urandom_range(0, 5) == 0)
      return 5'($urandom_range(0, 31));
    tz = int'($urandom_range(0, 26)) - 12;
    return tz[4:0];
  endfunction

  // Compare one field and report any difference
  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Check each strobed result against the oldest prediction
  always @(posedge clk) begin
    calendar_t want;
    if (!rst && done) begin
      if (pending_dates.size() == 0) begin
        $error("result with no request outstanding: %0d-%0d-%0d", year, month, day);
        mismatches++;
      end else begin
        want = pending_dates.pop_front();
        check_field("year", 32'(want.year), 32'(year));
        check_field("month", 32'(want.month), 32'(month));
        check_field("day", 32'(want.day), 32'(day));
        check_field("hour", 32'(want.hour), 32'(hour));
        check_field("minute", 32'(want.minute), 32'(minute));
        check_field("second", 32'(want.second), 32'(second));
        check_field("clamped", 32'(want.clamped), 32'(clamped));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Epoch, top of range and the century leap-year edges at UTC
  task automatic test_utc_edges();
    write_offset(5'd0);
    send_request(32'd0);
    send_request(TimeMax);
    send_request(32'h7FFF_FFFF);
    send_request(32'h8000_0000);
    send_request(32'd86399);
    send_request(32'd86400);
    send_request(Y2000Feb29 - 1);
    send_request(Y2000Feb29);
    send_request(Y2100Mar01 - 1);
    send_request(Y2100Mar01);
  endtask

  // Clamping at the epoch and saturation at the top, offsets at both extremes
  task automatic test_offset_extremes();
    write_offset(5'(-12));
    send_request(32'd0);
    send_request(32'd43199);
    send_request(32'd43200);
    send_request(TimeMax);
    write_offset(5'd14);
    send_request(TimeMax);
    send_request(TimeMax - 32'd50400);
    send_request(TimeMax - 32'd50399);
    send_request(32'd0);
  endtask

  // Register values outside the stated range are used as written
  task automatic test_offset_out_of_range();
    write_offset(5'(-16));
    send_request(32'd57599);
    send_request(32'd57600);
    send_request(32'd1);
    write_offset(5'd15);
    send_request(TimeMax - 32'd54000);
    send_request(TimeMax - 32'd53999);
    write_offset(5'(-1));
    send_request(32'd3599);
    send_request(32'd3600);
  endtask

  // Random requests under several offsets at one idling rate
  task automatic test_random_phase(input int unsigned pct, input int unsigned count);
    idle_pct = pct;
    for (int seg = 0; seg < 4; seg++) begin
      write_offset(pick_offset());
      for (int i = 0; i < count; i++) begin
        sender_gap();
        send_request(pick_time());
      end
    end
  endtask

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    unix_time   = '0;
    cfg_valid   = 1'b0;
    utc_offset  = '0;
    tz_setting  = '0;
    mismatches  = 0;
    cycle_count = 0;
    idle_pct    = 0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    test_utc_edges();
    test_offset_extremes();
    test_offset_out_of_range();
    test_random_phase(0, 80);
    test_random_phase(52, 80);
    test_random_phase(0, 80);
    test_random_phase(16, 80);

    // Let the last results land, then report
    drain();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
